FILE: rtl/core/nolt_pkg.sv
// ============================================================================
// nolt_pkg - shared definitions for the line-start lookup block
// Sizes, action and status codes, and the controller/datapath bundles.
// ============================================================================
package nolt_pkg;

  // Table geometry
  localparam int unsigned MAX_LINES   = 1024;
  localparam int unsigned OFFSET_BITS = 32;
  localparam int unsigned IDX_W       = $clog2(MAX_LINES);
  localparam int unsigned CNT_W       = $clog2(MAX_LINES + 1);

  // Field widths
  localparam int unsigned ACT_W  = 2;
  localparam int unsigned POS_W  = 32;
  localparam int unsigned LINE_W = 32;
  localparam int unsigned COL_W  = 32;
  localparam int unsigned STS_W  = 2;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_APPEND = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

  // Status codes
  localparam logic [STS_W-1:0] STS_OK    = 2'd0;
  localparam logic [STS_W-1:0] STS_FULL  = 2'd1;
  localparam logic [STS_W-1:0] STS_ORDER = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic accept;      // latch the incoming item
    logic app_check;   // check and store an appended line start
    logic srch_issue;  // first search probe from the initial bounds
    logic srch_step;   // narrow bounds and issue the next probe
    logic load_out;    // move the result into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic srch_done;   // search bounds have met
    logic out_free;    // output register can take a result
  } sts_t;

endpackage

FILE: rtl/core/nolt_req_if.sv
// ============================================================================
// nolt_req_if - request channel
// Carries one action and byte position per item with valid/ready.
// ============================================================================
interface nolt_req_if;
  logic                               valid;
  logic                               ready;
  logic [nolt_pkg::ACT_W-1:0]         action;
  logic [nolt_pkg::POS_W-1:0]         position;

  modport source (output valid, output action, output position, input ready);
  modport sink   (input valid, input action, input position, output ready);
endinterface

FILE: rtl/core/nolt_rsp_if.sv
// ============================================================================
// nolt_rsp_if - response channel
// Carries line, column and status per item with valid/ready.
// ============================================================================
interface nolt_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [nolt_pkg::LINE_W-1:0] line;
  logic [nolt_pkg::COL_W-1:0]         column;
  logic [nolt_pkg::STS_W-1:0]         status;

  modport source (output valid, output line, output column, output status, input ready);
  modport sink   (input valid, input line, input column, input status, output ready);
endinterface

FILE: rtl/core/nolt_cfg_if.sv
// ============================================================================
// nolt_cfg_if - configuration write channel
// Carries the first line number with valid/ready.
// ============================================================================
interface nolt_cfg_if;
  logic                               valid;
  logic                               ready;
  logic signed [nolt_pkg::LINE_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/nolt_datapath.sv
// ============================================================================
// nolt_datapath - line-start table and search datapath
// Holds the table memory, line count, search bounds and output register.
// ============================================================================
module nolt_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  nolt_pkg::cmd_t                     cmd_i,
  output nolt_pkg::sts_t                     sts_o,
  input  logic [nolt_pkg::ACT_W-1:0]         in_action_i,
  input  logic [nolt_pkg::POS_W-1:0]         in_position_i,
  input  logic                               cfg_valid_i,
  input  logic signed [nolt_pkg::LINE_W-1:0] cfg_data_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic signed [nolt_pkg::LINE_W-1:0] out_line_o,
  output logic [nolt_pkg::COL_W-1:0]         out_column_o,
  output logic [nolt_pkg::STS_W-1:0]         out_status_o
);

  localparam int unsigned IDX_W = nolt_pkg::IDX_W;
  localparam int unsigned CNT_W = nolt_pkg::CNT_W;
  localparam int unsigned OFF_W = nolt_pkg::OFFSET_BITS;

  // Table memory; entry 0 is never written and reads as zero
  logic [OFF_W-1:0] mem_q [nolt_pkg::MAX_LINES];
  logic [OFF_W-1:0] rd_raw_q;
  logic             rd_zero_q;

  logic [CNT_W-1:0]           count_q;
  logic [nolt_pkg::LINE_W-1:0] first_q;
  logic [OFF_W-1:0]           pos_q;
  logic [nolt_pkg::ACT_W-1:0] act_q;
  logic [IDX_W-1:0]           lo_q, hi_q, mid_q;
  logic [OFF_W-1:0]           lo_val_q;
  logic [nolt_pkg::STS_W-1:0] status_q;

  logic                               out_valid_q;
  logic [nolt_pkg::LINE_W-1:0]        out_line_q;
  logic [nolt_pkg::COL_W-1:0]         out_column_q;
  logic [nolt_pkg::STS_W-1:0]         out_status_q;

  logic [OFF_W-1:0] rdata;
  logic [OFF_W-1:0] new_val;
  logic [IDX_W-1:0] last_idx;
  logic             full;
  logic             wr_en;
  logic             probe_le;
  logic [IDX_W-1:0] lo_n, hi_n, lo_b, hi_b, mid_b, rd_addr;
  logic [OFF_W-1:0] lo_val_n;
  logic [CNT_W-1:0] span;

  // Read data with entry 0 forced to zero
  assign rdata    = rd_zero_q ? '0 : rd_raw_q;
  assign last_idx = IDX_W'(count_q - CNT_W'(1));
  assign new_val  = pos_q + OFF_W'(1);
  assign full     = (count_q == CNT_W'(nolt_pkg::MAX_LINES));
  assign wr_en    = cmd_i.app_check && !full && (new_val > rdata);

  // Narrow the search bounds on the probe just read
  assign probe_le = (rdata <= pos_q);
  assign lo_n     = probe_le ? mid_q : lo_q;
  assign hi_n     = probe_le ? hi_q : (mid_q - IDX_W'(1));
  assign lo_val_n = probe_le ? rdata : lo_val_q;

  // Next probe: upper middle of the current bounds
  assign lo_b    = cmd_i.srch_step ? lo_n : lo_q;
  assign hi_b    = cmd_i.srch_step ? hi_n : hi_q;
  assign span    = {1'b0, hi_b} - {1'b0, lo_b} + CNT_W'(1);
  assign mid_b   = IDX_W'({1'b0, lo_b} + (span >> 1));
  assign rd_addr = (cmd_i.srch_issue || cmd_i.srch_step) ? mid_b : last_idx;

  assign sts_o.srch_done = (lo_b == hi_b);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // Memory write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[IDX_W'(count_q)] <= new_val;
    end
    rd_raw_q  <= mem_q[rd_addr];
    rd_zero_q <= (rd_addr == '0);
  end

  // Item and search registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pos_q    <= in_position_i[OFF_W-1:0];
      act_q    <= in_action_i;
      lo_q     <= '0;
      hi_q     <= last_idx;
      lo_val_q <= '0;
      status_q <= nolt_pkg::STS_OK;
    end
    if (cmd_i.srch_issue || cmd_i.srch_step) begin
      mid_q <= mid_b;
    end
    if (cmd_i.srch_step) begin
      lo_q     <= lo_n;
      hi_q     <= hi_n;
      lo_val_q <= lo_val_n;
    end
    if (cmd_i.app_check) begin
      if (full) begin
        status_q <= nolt_pkg::STS_FULL;
      end else if (new_val <= rdata) begin
        status_q <= nolt_pkg::STS_ORDER;
      end
    end
  end

  // Line count and first line number
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CNT_W'(1);
      first_q <= nolt_pkg::LINE_W'(1);
    end else begin
      if (cmd_i.accept && (in_action_i == nolt_pkg::ACT_CLEAR)) begin
        count_q <= CNT_W'(1);
      end else if (wr_en) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (cfg_valid_i) begin
        first_q <= cfg_data_i;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      if (act_q == nolt_pkg::ACT_LOOKUP) begin
        out_line_q   <= first_q + nolt_pkg::LINE_W'(lo_q);
        out_column_q <= nolt_pkg::COL_W'(pos_q - lo_val_q);
      end else begin
        out_line_q   <= '0;
        out_column_q <= '0;
      end
      out_status_q <= status_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_line_o   = out_line_q;
  assign out_column_o = out_column_q;
  assign out_status_o = out_status_q;

endmodule

FILE: rtl/core/nolt_ctrl.sv
// ============================================================================
// nolt_ctrl - sequencer for append, lookup and clear
// Accepts one item at a time and steps the datapath through it.
// ============================================================================
module nolt_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic [nolt_pkg::ACT_W-1:0] in_action_i,
  output logic                       in_ready_o,
  input  nolt_pkg::sts_t             sts_i,
  output nolt_pkg::cmd_t             cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APP_CHECK,
    ST_SRCH_ISSUE,
    ST_SRCH_STEP,
    ST_RESULT
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          case (in_action_i)
            nolt_pkg::ACT_APPEND: state_d = ST_APP_CHECK;
            nolt_pkg::ACT_LOOKUP: state_d = ST_SRCH_ISSUE;
            default:              state_d = ST_RESULT;
          endcase
        end
      end
      ST_APP_CHECK: begin
        cmd_o.app_check = 1'b1;
        state_d         = ST_RESULT;
      end
      ST_SRCH_ISSUE: begin
        cmd_o.srch_issue = 1'b1;
        state_d          = sts_i.srch_done ? ST_RESULT : ST_SRCH_STEP;
      end
      ST_SRCH_STEP: begin
        cmd_o.srch_step = 1'b1;
        if (sts_i.srch_done) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/core/newline_offset_line_lookup.sv
// ============================================================================
// newline_offset_line_lookup - line-start table with line/column lookup
// Sorted table of line-start offsets, searched by bisection.
// ============================================================================
// Usage:
//   req_i carries one item: action (append, lookup, clear) and a byte position.
//   rsp_o returns exactly one item per request: line, column and status.
//   cfg_i writes the first line number; it is always ready and should only
//   be written while no request is in flight.
//   Append stores position+1 as the next line start, or reports table full
//   or out of order. Clear drops the table back to the single entry 0.
//   Lookup bisects the table with one memory probe per cycle.
// Sequence (accept to response): append runs a check state, clear and unused
//   action go straight to the result state, lookup issues a first probe and
//   then steps the bounds until they meet. The search is bound by the single
//   registered read port of the table memory.
// Flow: one item at a time; the next item is taken the cycle after the
//   response is loaded.
// Reset: line count returns to one, first line number to 1, no response
//   pending. No clearing pass is needed.
// Stall: a finished response waits in the output register; the block holds
//   its result state until that register frees up.
// ============================================================================
module newline_offset_line_lookup (
  input  logic       clk_i,
  input  logic       rst_ni,
  nolt_req_if.sink   req_i,
  nolt_rsp_if.source rsp_o,
  nolt_cfg_if.sink   cfg_i
);

  nolt_pkg::cmd_t cmd;
  nolt_pkg::sts_t sts;

  assign cfg_i.ready = 1'b1;

  nolt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_action_i (req_i.action),
    .in_ready_o  (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  nolt_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_action_i   (req_i.action),
    .in_position_i (req_i.position),
    .cfg_valid_i   (cfg_i.valid),
    .cfg_data_i    (cfg_i.data),
    .out_ready_i   (rsp_o.ready),
    .out_valid_o   (rsp_o.valid),
    .out_line_o    (rsp_o.line),
    .out_column_o  (rsp_o.column),
    .out_status_o  (rsp_o.status)
  );

  // One item in flight: after an accept the request side stays closed
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request accepted while previous item still in flight");

  // A result is loaded only into a free output register
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> sts.out_free)
    else $error("result loaded over a pending response");

  // Dropped appends carry zero line and column
  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.status != nolt_pkg::STS_OK))
      |-> ((rsp_o.line == '0) && (rsp_o.column == '0)))
    else $error("error response with nonzero line or column");

  // The controller issues at most one command per cycle
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.accept, cmd.app_check, cmd.srch_issue, cmd.srch_step, cmd.load_out}))
    else $error("overlapping controller commands");

endmodule

FILE: sim/newline_offset_line_lookup_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// newline_offset_line_lookup_tb - self-checking bench for the line lookup
// Feeds append, lookup, clear and unused actions with random idle on both
// channels. Each accepted item is run through a local line-start table to
// predict line, column and status. Responses are checked in order, field by
// field. Phases switch the first line number between extreme and random values, and
// one phase fills the table to its limit.
// ============================================================================
module newline_offset_line_lookup_tb;
  import nolt_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNUSED  = 2'd3;
  localparam int               CYCLE_LIMIT = 400000;
  localparam int               SETTLE_CYC  = 24;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [POS_W-1:0] position;
  } req_item_t;

  typedef struct packed {
    logic signed [LINE_W-1:0] line;
    logic [COL_W-1:0]         column;
    logic [STS_W-1:0]         status;
  } line_col_t;

  logic clk = 1'b0;
  logic rst_n;

  nolt_req_if req_bus ();
  nolt_rsp_if rsp_bus ();
  nolt_cfg_if cfg_bus ();

  newline_offset_line_lookup uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus),
    .cfg_i  (cfg_bus)
  );

  // Local copy of the table, its count and the first line number
  logic [OFFSET_BITS-1:0] line_start [MAX_LINES];
  int                     line_cnt   = 1;
  logic [LINE_W-1:0]      first_line = 32'd1;

  // Line starts as the stimulus side expects them to be stored
  logic [POS_W-1:0] gen_starts [$];

  req_item_t pending_req [$];
  line_col_t expected_line_col [$];

  int   errors    = 0;
  int   cycles    = 0;
  logic req_fired;
  int   req_gap   = 0;
  int   rsp_gap   = 0;
  bit   idle_req_on;
  bit   idle_rsp_on;
  bit   tail_mode;

  // Clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Apply one item to the local table and return its response
  function automatic line_col_t step_line_table(input logic [ACT_W-1:0] act,
                                                input logic [POS_W-1:0] pos);
    line_col_t        res;
    logic [POS_W-1:0] nxt;
    int               lo;
    int               hi;
    int               mid;
    res = '0;
    case (act)
      ACT_APPEND: begin
        nxt = pos + 32'd1;
        if (line_cnt >= MAX_LINES) begin
          res.status = STS_FULL;
        end else if (nxt <= line_start[line_cnt-1]) begin
          res.status = STS_ORDER;
        end else begin
          line_start[line_cnt] = nxt;
          line_cnt++;
        end
      end
      ACT_LOOKUP: begin
        // Last start that is not above the position
        lo = 0;
        hi = line_cnt - 1;
        while (lo < hi) begin
          mid = lo + (hi - lo + 1) / 2;
          if (line_start[mid] <= pos) lo = mid;
          else hi = mid - 1;
        end
        res.line   = first_line + 32'(lo);
        res.column = pos - line_start[lo];
      end
      ACT_CLEAR: line_cnt = 1;
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] %s", $time, msg);
    errors++;
  endtask

  // Queue one item and track which line starts it should add
  task automatic add_item(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos);
    logic [POS_W-1:0] nxt;
    nxt = pos + 32'd1;
    pending_req.push_back('{action: act, position: pos});
    if (act == ACT_APPEND && gen_starts.size() < MAX_LINES && nxt > gen_starts[$]) begin
      gen_starts.push_back(nxt);
    end else if (act == ACT_CLEAR) begin
      gen_starts = '{32'd0};
    end
  endtask

  // Position on or near a stored line start
  function automatic logic [POS_W-1:0] near_start();
    logic [POS_W-1:0] s;
    s = gen_starts[$urandom_range(0, gen_starts.size() - 1)];
    case ($urandom_range(0, 3))
      0: return s;
      1: return s - 32'd1;
      2: return s + $urandom_range(0, 5);
      default: return s + $urandom_range(0, 1 << 16);
    endcase
  endfunction

  // Mostly ordered appends and lookups near known starts, some noise
  task automatic queue_mixed(input int n);
    logic [32:0] p;
    int          r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        p = {1'b0, gen_starts[$]} +
            (($urandom_range(0, 3) == 0) ? $urandom_range(0, 1 << 24) : $urandom_range(0, 200));
        if (p > 33'h0_FFFF_FFFE) p = 33'h0_FFFF_FFFE;
        add_item(ACT_APPEND, p[31:0]);
      end else if (r < 75) begin
        add_item(ACT_LOOKUP, near_start());
      end else if (r < 85) begin
        add_item(ACT_LOOKUP, $urandom);
      end else if (r < 92) begin
        add_item(ACT_APPEND, $urandom);
      end else if (r < 96) begin
        add_item(ACT_CLEAR, $urandom);
      end else begin
        add_item(ACT_UNUSED, $urandom);
      end
    end
  endtask

  // Fill the table to its limit with lookups in between, then overflow it
  task automatic queue_fill();
    logic [32:0] p;
    add_item(ACT_CLEAR, $urandom);
    while (gen_starts.size() < MAX_LINES) begin
      if ($urandom_range(0, 9) == 0) begin
        add_item(ACT_LOOKUP, near_start());
      end else begin
        p = {1'b0, gen_starts[$]} +
            (($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 4000000));
        if (p > 33'h0_FFFF_FFFE) p = 33'h0_FFFF_FFFE;
        add_item(ACT_APPEND, p[31:0]);
      end
    end
    // Full takes precedence over out of order
    add_item(ACT_APPEND, 32'd0);
    add_item(ACT_APPEND, 32'hFFFF_FFFE);
    add_item(ACT_APPEND, $urandom);
    for (int i = 0; i < 30; i++) begin
      add_item(ACT_LOOKUP, ($urandom_range(0, 3) == 0) ? $urandom : near_start());
    end
  endtask

  // Wait until every item has been taken and answered
  task automatic drain();
    while (pending_req.size() != 0 || req_bus.valid || expected_line_col.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_first_line(input logic [LINE_W-1:0] value);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    first_line = value;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // Settle the block, pick idle behavior, then set the first line number
  task automatic begin_phase(input logic [LINE_W-1:0] value, input bit tail);
    drain();
    tail_mode   = tail;
    idle_req_on = !tail && ($urandom_range(0, 3) != 0);
    idle_rsp_on = !tail && ($urandom_range(0, 3) != 0);
    write_first_line(value);
  endtask

  // Request driver: hold until taken, idle in bursts, else send next item
  always @(negedge clk) begin : drive_req
    req_item_t item;
    if (!rst_n) begin
      req_bus.valid <= 1'b0;
    end else if (req_bus.valid && !req_fired) begin
      // hold the current item
    end else if (req_gap > 0) begin
      req_gap       <= req_gap - 1;
      req_bus.valid <= 1'b0;
    end else if (idle_req_on && !tail_mode && $urandom_range(0, 7) == 0) begin
      req_gap       <= $urandom_range(0, 14);
      req_bus.valid <= 1'b0;
    end else if (pending_req.size() != 0) begin
      item             = pending_req.pop_front();
      req_bus.action   <= item.action;
      req_bus.position <= item.position;
      req_bus.valid    <= 1'b1;
    end else begin
      req_bus.valid <= 1'b0;
    end
  end

  // Response ready: stall in bursts
  always @(negedge clk) begin
    if (!rst_n) begin
      rsp_bus.ready <= 1'b0;
    end else if (rsp_gap > 0) begin
      rsp_gap       <= rsp_gap - 1;
      rsp_bus.ready <= 1'b0;
    end else if (idle_rsp_on && !tail_mode && $urandom_range(0, 7) == 0) begin
      rsp_gap       <= $urandom_range(0, 14);
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= 1'b1;
    end
  end

  // Monitor: predict on accept, check each response against the oldest
  always @(posedge clk) begin : watch
    line_col_t want;
    if (!rst_n) begin
      req_fired <= 1'b0;
    end else begin
      req_fired <= req_bus.valid && req_bus.ready;
      if (req_bus.valid && req_bus.ready) begin
        expected_line_col.push_back(step_line_table(req_bus.action, req_bus.position));
      end
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (expected_line_col.size() == 0) begin
          report_mismatch($sformatf("response with none pending: line %h column %h status %0d",
                                    rsp_bus.line, rsp_bus.column, rsp_bus.status));
        end else begin
          want = expected_line_col.pop_front();
          if (rsp_bus.line !== want.line)
            report_mismatch($sformatf("line got %h want %h", rsp_bus.line, want.line));
          if (rsp_bus.column !== want.column)
            report_mismatch($sformatf("column got %h want %h", rsp_bus.column, want.column));
          if (rsp_bus.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", rsp_bus.status, want.status));
        end
      end
    end
  end

  // Timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("newline_offset_line_lookup: mismatch");
      $finish;
    end
  end

  initial begin : run
    rst_n            = 1'b0;
    req_bus.valid    = 1'b0;
    req_bus.action   = ACT_APPEND;
    req_bus.position = '0;
    rsp_bus.ready    = 1'b0;
    cfg_bus.valid    = 1'b0;
    cfg_bus.data     = '0;
    line_start[0]    = '0;
    gen_starts       = '{32'd0};
    idle_req_on      = 1'b1;
    idle_rsp_on      = 1'b1;
    tail_mode        = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset first line number, edges of position, wrap, unused
    add_item(ACT_LOOKUP, 32'd0);
    add_item(ACT_LOOKUP, 32'hFFFF_FFFF);
    add_item(ACT_APPEND, 32'hFFFF_FFFF);
    add_item(ACT_APPEND, 32'd0);
    add_item(ACT_APPEND, 32'd0);
    add_item(ACT_APPEND, 32'd9);
    add_item(ACT_LOOKUP, 32'd0);
    add_item(ACT_LOOKUP, 32'd1);
    add_item(ACT_LOOKUP, 32'd9);
    add_item(ACT_LOOKUP, 32'd10);
    add_item(ACT_APPEND, 32'hFFFF_FFFD);
    add_item(ACT_APPEND, 32'hFFFF_FFFE);
    add_item(ACT_LOOKUP, 32'hFFFF_FFFF);
    add_item(ACT_LOOKUP, 32'hFFFF_FFFE);
    add_item(ACT_LOOKUP, 32'hFFFF_FFFD);
    add_item(ACT_APPEND, 32'hFFFF_FFFF);
    add_item(ACT_UNUSED, 32'hFFFF_FFFF);
    add_item(ACT_UNUSED, 32'd0);
    add_item(ACT_CLEAR, 32'd0);
    add_item(ACT_LOOKUP, 32'h8000_0000);
    add_item(ACT_APPEND, 32'h7FFF_FFFF);
    add_item(ACT_LOOKUP, 32'h8000_0000);
    add_item(ACT_CLEAR, 32'hFFFF_FFFF);

    // Random phases over extreme and random first line numbers
    begin_phase(32'h7FFF_FFFF, 1'b0);
    queue_mixed(40);
    begin_phase(32'h8000_0000, 1'b0);
    queue_mixed(40);
    begin_phase(32'd0, 1'b0);
    queue_fill();
    begin_phase($urandom, 1'b0);
    queue_mixed(40);
    begin_phase(32'hFFFF_FFFF, 1'b1);
    queue_mixed(40);

    drain();
    repeat (SETTLE_CYC) @(negedge clk);
    if (expected_line_col.size() != 0)
      report_mismatch($sformatf("%0d responses never arrived", expected_line_col.size()));
    if (errors == 0) begin
      $display("newline_offset_line_lookup: match");
    end else begin
      $display("newline_offset_line_lookup: mismatch");
    end
    $finish;
  end

endmodule
